// ===== hdl/ted_pkg.sv =====
// ted_pkg: types, byte constants and the UTF-8 scan step for the text encoding detector.
// No dependencies.
`default_nettype none
package ted_pkg;

  localparam logic [7:0] ByteFf   = 8'hFF;
  localparam logic [7:0] ByteFe   = 8'hFE;
  localparam logic [7:0] ByteEf   = 8'hEF;
  localparam logic [7:0] ByteBb   = 8'hBB;
  localparam logic [7:0] ByteBf   = 8'hBF;
  localparam logic [7:0] Byte80   = 8'h80;
  localparam logic [7:0] ByteC0   = 8'hC0;
  localparam logic [7:0] ByteE0   = 8'hE0;
  localparam logic [7:0] ByteF0   = 8'hF0;
  localparam logic [7:0] ContMask = 8'hC0;

  typedef enum logic [2:0] {
    PhFirst,
    PhSecond,
    PhThird,
    PhScan,
    PhScanPend,
    PhDone
  } phase_e;

  typedef enum logic [2:0] {
    VerdUnknown,
    VerdU16Le,
    VerdU16Be,
    VerdU8Bom,
    VerdU8,
    VerdAnsi
  } verdict_e;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  cont;
    verdict_e    verdict;
  } scan_t;

  // one byte of the UTF-8 scan
  function automatic scan_t scan_byte(scan_t s, logic [7:0] b);
    scan_t r;
    logic  bad;
    r   = s;
    bad = ((b & ContMask) != Byte80);
    if (s.phase != PhDone) begin
      if (s.cont == 2'd0) begin
        r.phase = PhScan;
        if (b < Byte80) begin
          r.cont = 2'd0;
        end else if (b < ByteC0) begin
          r = '{phase: PhDone, cont: 2'd0, verdict: VerdAnsi};
        end else if (b < ByteE0) begin
          r.cont = 2'd1;
        end else if (b < ByteF0) begin
          r.cont = 2'd2;
        end else begin
          r = '{phase: PhDone, cont: 2'd0, verdict: VerdAnsi};
        end
      end else if (s.cont >= 2'd2) begin
        r.phase = bad ? PhScanPend : PhScan;
        r.cont  = 2'd1;
      end else if (bad || (s.phase == PhScanPend)) begin
        r = '{phase: PhDone, cont: 2'd0, verdict: VerdAnsi};
      end else begin
        r.cont  = 2'd0;
        r.phase = PhScan;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ted_in_if.sv =====
// ted_in_if: byte request channel (valid/ready, data byte, last flag).
// Depends on nothing.
`default_nettype none
interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/ted_out_if.sv =====
// ted_out_if: verdict request channel (valid/ready, 3-bit verdict).
// Depends on nothing.
`default_nettype none
interface ted_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// ===== hdl/text_encoding_detector_core.sv =====
// text_encoding_detector_core: BOM detection and UTF-8 validation over a byte stream.
// Depends on ted_pkg, ted_in_if, ted_out_if.
//
// Channel    Dir  Payload                    Request
// byte_i     in   data_byte[7:0], last_byte  one file byte
// verdict_o  out  verdict[2:0]               one verdict per file, on the last byte
//
// One byte per cycle while byte_i.ready is high; the verdict is registered and appears the cycle after the last byte.
// byte_i.ready is low only while a verdict is held and verdict_o.ready is low.
// Reset clears the scan state and drops any pending verdict.
// After each verdict the scan state returns to its reset values for the next file.
`default_nettype none
module text_encoding_detector_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ted_in_if.sink     byte_i,
  ted_out_if.source  verdict_o
);

  ted_pkg::phase_e   phase_q, phase_d;
  logic [1:0]        cont_q, cont_d;
  ted_pkg::verdict_e run_q, run_d;
  logic [7:0]        held_q, held_d;
  logic              out_valid_q, out_valid_d;
  ted_pkg::verdict_e out_verdict_q, out_verdict_d;

  ted_pkg::scan_t    cur, nxt, seed;
  logic              in_acc;
  logic [7:0]        b;

  assign byte_i.ready      = !out_valid_q || verdict_o.ready;
  assign in_acc            = byte_i.valid && byte_i.ready;
  assign b                 = byte_i.data_byte;
  assign verdict_o.valid   = out_valid_q;
  assign verdict_o.verdict = out_verdict_q;

  always_comb begin
    cur    = '{phase: phase_q, cont: cont_q, verdict: run_q};
    nxt    = cur;
    seed   = '{phase: ted_pkg::PhScan, cont: 2'd0, verdict: run_q};
    held_d = held_q;
    unique case (phase_q)
      ted_pkg::PhFirst: begin
        if (byte_i.last_byte) begin
          nxt = ted_pkg::scan_byte('{phase: ted_pkg::PhScan, cont: cont_q, verdict: run_q}, b);
        end else begin
          held_d    = b;
          nxt.phase = ted_pkg::PhSecond;
        end
      end
      ted_pkg::PhSecond: begin
        priority if (held_q == ted_pkg::ByteFf && b == ted_pkg::ByteFe) begin
          nxt.verdict = ted_pkg::VerdU16Le;
          nxt.phase   = ted_pkg::PhDone;
        end else if (held_q == ted_pkg::ByteFe && b == ted_pkg::ByteFf) begin
          nxt.verdict = ted_pkg::VerdU16Be;
          nxt.phase   = ted_pkg::PhDone;
        end else if (held_q == ted_pkg::ByteEf && b == ted_pkg::ByteBb) begin
          nxt.verdict = ted_pkg::VerdUnknown;
          nxt.phase   = byte_i.last_byte ? ted_pkg::PhDone : ted_pkg::PhThird;
        end else begin
          nxt = ted_pkg::scan_byte(ted_pkg::scan_byte(seed, held_q), b);
        end
      end
      ted_pkg::PhThird: begin
        nxt.verdict = (b == ted_pkg::ByteBf) ? ted_pkg::VerdU8Bom : ted_pkg::VerdUnknown;
        nxt.phase   = ted_pkg::PhDone;
      end
      ted_pkg::PhScan, ted_pkg::PhScanPend: begin
        nxt = ted_pkg::scan_byte(cur, b);
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    phase_d       = phase_q;
    cont_d        = cont_q;
    run_d         = run_q;
    out_valid_d   = out_valid_q && !verdict_o.ready;
    out_verdict_d = out_verdict_q;
    if (in_acc) begin
      if (byte_i.last_byte) begin
        phase_d       = ted_pkg::PhFirst;
        cont_d        = 2'd0;
        run_d         = ted_pkg::VerdU8;
        out_valid_d   = 1'b1;
        out_verdict_d = nxt.verdict;
      end else begin
        phase_d = nxt.phase;
        cont_d  = nxt.cont;
        run_d   = nxt.verdict;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ted_pkg::PhFirst;
      cont_q      <= 2'd0;
      run_q       <= ted_pkg::VerdU8;
      held_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cont_q      <= cont_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        held_q <= byte_i.last_byte ? 8'd0 : held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_verdict_q <= out_verdict_d;
  end

endmodule
`default_nettype wire

// ===== hdl/ted_checker.sv =====
// ted_checker: port-level assertions for text_encoding_detector_core, and its bind.
// Depends on text_encoding_detector_core, ted_in_if, ted_out_if.
`default_nettype none
module ted_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       in_last_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_verdict_i
);

  // held verdict stays put under back-pressure
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_verdict_i))
    else $error("verdict dropped or changed while stalled");

  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_verdict_i <= 3'd5))
    else $error("verdict code out of range");

  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("no verdict after last byte");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i && (!out_valid_i || out_ready_i) |=> !out_valid_i)
    else $error("verdict without last byte");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no verdict pending");

endmodule

bind text_encoding_detector_core ted_checker u_ted_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .in_last_i    (byte_i.last_byte),
  .out_valid_i  (verdict_o.valid),
  .out_ready_i  (verdict_o.ready),
  .out_verdict_i(verdict_o.verdict)
);
`default_nettype wire

// ===== tb/text_encoding_detector_core_tb.sv =====
// text_encoding_detector_core_tb: byte-order mark and UTF-8 checks on the encoding detector,
// predicted per byte and compared per verdict under random idling on both channels.
// Depends on ted_pkg, ted_in_if, ted_out_if and text_encoding_detector_core.
`default_nettype none
module text_encoding_detector_core_tb;

  localparam int CycleLimit = 100000;

  logic clk_i;
  logic rst_ni;

  ted_in_if  byte_if ();
  ted_out_if verd_if ();

  text_encoding_detector_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_if),
    .verdict_o (verd_if)
  );

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int verdicts_seen = 0;

  // predicted detector state
  ted_pkg::phase_e   enc_phase = ted_pkg::PhFirst;
  logic [7:0]        first_byte = 8'h00;
  logic [1:0]        owed_cont = 2'd0;
  ted_pkg::verdict_e enc_verdict = ted_pkg::VerdU8;

  ted_pkg::verdict_e expected_verdicts[$];
  logic [7:0]        file_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    verd_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               expected_verdicts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void append_byte(input logic [7:0] b);
    file_q = {file_q, b};
  endfunction

  function automatic void mark_ansi();
    enc_verdict = ted_pkg::VerdAnsi;
    owed_cont   = 2'd0;
    enc_phase   = ted_pkg::PhDone;
  endfunction

  // UTF-8 validation of one byte
  function automatic void utf8_advance(input logic [7:0] b);
    logic bad_cont;
    bad_cont = (b[7:6] != 2'b10);
    if (enc_phase != ted_pkg::PhDone) begin
      if (owed_cont == 2'd0) begin
        enc_phase = ted_pkg::PhScan;
        casez (b)
          8'b0???????: ;
          8'b110?????: owed_cont = 2'd1;
          8'b1110????: owed_cont = 2'd2;
          default:     mark_ansi();
        endcase
      end else if (owed_cont == 2'd2) begin
        enc_phase = bad_cont ? ted_pkg::PhScanPend : ted_pkg::PhScan;
        owed_cont = 2'd1;
      end else if (bad_cont || enc_phase == ted_pkg::PhScanPend) begin
        mark_ansi();
      end else begin
        owed_cont = 2'd0;
        enc_phase = ted_pkg::PhScan;
      end
    end
  endfunction

  function automatic void take_file_byte(input logic [7:0] b, input logic is_last);
    case (enc_phase)
      ted_pkg::PhFirst: begin
        if (is_last) begin
          enc_phase = ted_pkg::PhScan;
          utf8_advance(b);
        end else begin
          first_byte = b;
          enc_phase  = ted_pkg::PhSecond;
        end
      end
      ted_pkg::PhSecond: begin
        if (first_byte == ted_pkg::ByteFf && b == ted_pkg::ByteFe) begin
          enc_verdict = ted_pkg::VerdU16Le;
          enc_phase   = ted_pkg::PhDone;
        end else if (first_byte == ted_pkg::ByteFe && b == ted_pkg::ByteFf) begin
          enc_verdict = ted_pkg::VerdU16Be;
          enc_phase   = ted_pkg::PhDone;
        end else if (first_byte == ted_pkg::ByteEf && b == ted_pkg::ByteBb) begin
          enc_verdict = ted_pkg::VerdUnknown;
          enc_phase   = is_last ? ted_pkg::PhDone : ted_pkg::PhThird;
        end else begin
          enc_phase = ted_pkg::PhScan;
          owed_cont = 2'd0;
          utf8_advance(first_byte);
          utf8_advance(b);
        end
      end
      ted_pkg::PhThird: begin
        enc_verdict = (b == ted_pkg::ByteBf) ? ted_pkg::VerdU8Bom : ted_pkg::VerdUnknown;
        enc_phase   = ted_pkg::PhDone;
      end
      ted_pkg::PhScan, ted_pkg::PhScanPend: utf8_advance(b);
      default: ;
    endcase
    if (is_last) begin
      expected_verdicts = {expected_verdicts, enc_verdict};
      enc_phase   = ted_pkg::PhFirst;
      first_byte  = 8'h00;
      owed_cont   = 2'd0;
      enc_verdict = ted_pkg::VerdU8;
    end
  endfunction

  task automatic check_verdict(input logic [2:0] got);
    ted_pkg::verdict_e want;
    verdicts_seen++;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict %0d with no file pending", got));
    end else begin
      want = expected_verdicts.pop_front();
      if (got !== want)
        report_mismatch($sformatf("verdict %0d, expected %0d (%s)", got, want, want.name()));
    end
  endtask

  always @(posedge clk_i) begin
    if (byte_if.valid && byte_if.ready)
      take_file_byte(byte_if.data_byte, byte_if.last_byte);
    if (verd_if.valid && verd_if.ready)
      check_verdict(verd_if.verdict);
  end

  // one byte request, with random idling ahead of it
  task automatic send_request(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= is_last;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_request(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  function automatic void add_utf8_char();
    case ($urandom_range(2))
      0: append_byte({1'b0, 7'($urandom)});
      1: begin
        append_byte({3'b110, 5'($urandom)});
        append_byte({2'b10, 6'($urandom)});
      end
      default: begin
        append_byte({4'b1110, 4'($urandom)});
        append_byte({2'b10, 6'($urandom)});
        append_byte({2'b10, 6'($urandom)});
      end
    endcase
  endfunction

  task automatic build_random_file();
    int kind;
    int pos;
    file_q.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      case ($urandom_range(3))
        0:       file_q = '{ted_pkg::ByteFf, ted_pkg::ByteFe};
        1:       file_q = '{ted_pkg::ByteFe, ted_pkg::ByteFf};
        2:       file_q = '{ted_pkg::ByteEf, ted_pkg::ByteBb, ted_pkg::ByteBf};
        default: file_q = '{ted_pkg::ByteEf, ted_pkg::ByteBb};
      endcase
      repeat ($urandom_range(3)) append_byte(8'($urandom));
    end else if (kind < 30) begin
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) add_utf8_char();
      // corrupt: cut the tail or overwrite one byte
      if (kind < 50) begin
        if ($urandom_range(1) == 1 && file_q.size() > 1) begin
          void'(file_q.pop_back());
        end else begin
          pos = $urandom_range(file_q.size() - 1);
          file_q[pos] = 8'($urandom);
        end
      end
    end
  endtask

  task automatic test_byte_order_marks();
    file_q = '{ted_pkg::ByteFf, ted_pkg::ByteFe, 8'h00};
    send_file();
    file_q = '{ted_pkg::ByteFe, ted_pkg::ByteFf};
    send_file();
    file_q = '{ted_pkg::ByteEf, ted_pkg::ByteBb, ted_pkg::ByteBf};
    send_file();
    file_q = '{ted_pkg::ByteEf, ted_pkg::ByteBb};
    send_file();
    file_q = '{ted_pkg::ByteEf, ted_pkg::ByteBb, 8'h41};
    send_file();
  endtask

  task automatic test_single_byte_files();
    file_q = '{8'h00};
    send_file();
    file_q = '{ted_pkg::ByteFf};
    send_file();
    file_q = '{ted_pkg::Byte80};
    send_file();
  endtask

  task automatic test_cut_short_sequences();
    file_q = '{8'hE2, 8'h41};
    send_file();
    file_q = '{8'hE2, 8'h41, ted_pkg::Byte80};
    send_file();
    file_q = '{8'hE2, 8'h82, 8'hAC};
    send_file();
  endtask

  task automatic test_random_text(input int send_pct, input int recv_pct, input int n_bytes);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.last_byte = 1'b0;
    verd_if.ready     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_byte_order_marks();
    test_single_byte_files();
    test_cut_short_sequences();
    test_random_text(32, 57, 210);
    test_random_text(57, 32, 210);
    test_random_text(0, 0, 210);

    byte_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d files in %0d bytes sent, %0d verdicts checked, %0d mismatches",
             files_sent, bytes_sent, verdicts_seen, error_count);
    $display("covered: all BOM forms, single-byte files, cut-short and broken UTF-8, noise");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
